[rtl/core/mcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, request and result types for the mesh current solver.
// ----------------------------------------------------------------------------
package mcs_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	// product of two data words
	localparam int PROD_W  = 2 * DATA_W;
	// cofactor, difference of two products
	localparam int COF_W   = 2 * DATA_W + 1;
	// partial product, data word by one half of a cofactor
	localparam int PP_W    = 2 * DATA_W + 1;
	// data word by full cofactor
	localparam int TERM_W  = 3 * DATA_W + 1;
	// sum of three terms: determinant and numerators
	localparam int SUM_W   = 3 * DATA_W + 3;
	// divider remainder width
	localparam int REM_W   = SUM_W + DATA_W;
	// number of data-by-cofactor products
	localparam int NTERM   = 12;
	// pipeline depths
	localparam int ADJ_LAT = 6;
	localparam int DIV_LAT = DATA_W + 3;
	localparam int LATENCY = ADJ_LAT + DIV_LAT;

	typedef struct packed {
		logic                     mode;
		logic signed [DATA_W-1:0] self_1;
		logic signed [DATA_W-1:0] self_2;
		logic signed [DATA_W-1:0] self_3;
		logic signed [DATA_W-1:0] mutual_12;
		logic signed [DATA_W-1:0] mutual_13;
		logic signed [DATA_W-1:0] mutual_23;
		logic signed [DATA_W-1:0] source_1;
		logic signed [DATA_W-1:0] source_2;
		logic signed [DATA_W-1:0] source_3;
	} solve_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] current_1;
		logic signed [DATA_W-1:0] current_2;
		logic signed [DATA_W-1:0] current_3;
		logic                     singular;
	} solve_rsp_t;

	// determinant and numerators handed to the dividers
	typedef struct packed {
		logic                    valid;
		logic signed [SUM_W-1:0] det;
		logic signed [SUM_W-1:0] num_1;
		logic signed [SUM_W-1:0] num_2;
		logic signed [SUM_W-1:0] num_3;
	} adj_out_t;

endpackage

[rtl/core/mcs_adj.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_adj
// Six-stage pipeline forming the cofactors, the determinant and the
// adjugate-times-source numerators, all exact.
// ----------------------------------------------------------------------------
module mcs_adj (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mcs_pkg::solve_req_t req,
	output mcs_pkg::adj_out_t   result
);

	localparam int W = mcs_pkg::DATA_W;

	// stage 1: register, two-loop requests become a 3x3 with unit r33
	logic                valid_s1;
	logic signed [W-1:0] a_s1, b_s1, c_s1, d_s1, e_s1, f_s1, v1_s1, v2_s1, v3_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= req.self_1;
		b_s1  <= req.self_2;
		d_s1  <= req.mutual_12;
		v1_s1 <= req.source_1;
		v2_s1 <= req.source_2;
		if (req.mode) begin
			c_s1  <= req.self_3;
			e_s1  <= req.mutual_13;
			f_s1  <= req.mutual_23;
			v3_s1 <= req.source_3;
		end else begin
			c_s1  <= W'(1);
			e_s1  <= '0;
			f_s1  <= '0;
			v3_s1 <= '0;
		end
	end

	// stage 2: pairwise products
	localparam int XW = mcs_pkg::PROD_W;
	logic                            valid_s2;
	logic signed [mcs_pkg::PROD_W-1:0] bc_s2, ff_s2, ef_s2, dc_s2, df_s2, be_s2;
	logic signed [mcs_pkg::PROD_W-1:0] ac_s2, ee_s2, de_s2, af_s2, ab_s2, dd_s2;
	logic signed [W-1:0] a_s2, d_s2, e_s2, v1_s2, v2_s2, v3_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		bc_s2 <= XW'(b_s1) * XW'(c_s1);
		ff_s2 <= XW'(f_s1) * XW'(f_s1);
		ef_s2 <= XW'(e_s1) * XW'(f_s1);
		dc_s2 <= XW'(d_s1) * XW'(c_s1);
		df_s2 <= XW'(d_s1) * XW'(f_s1);
		be_s2 <= XW'(b_s1) * XW'(e_s1);
		ac_s2 <= XW'(a_s1) * XW'(c_s1);
		ee_s2 <= XW'(e_s1) * XW'(e_s1);
		de_s2 <= XW'(d_s1) * XW'(e_s1);
		af_s2 <= XW'(a_s1) * XW'(f_s1);
		ab_s2 <= XW'(a_s1) * XW'(b_s1);
		dd_s2 <= XW'(d_s1) * XW'(d_s1);
		a_s2  <= a_s1;
		d_s2  <= d_s1;
		e_s2  <= e_s1;
		v1_s2 <= v1_s1;
		v2_s2 <= v2_s1;
		v3_s2 <= v3_s1;
	end

	// stage 3: cofactors
	localparam int CW = mcs_pkg::COF_W;
	logic                 valid_s3;
	logic signed [CW-1:0] c11_s3, c12_s3, c13_s3, c22_s3, c23_s3, c33_s3;
	logic signed [W-1:0]  a_s3, d_s3, e_s3, v1_s3, v2_s3, v3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		c11_s3 <= CW'(bc_s2) - CW'(ff_s2);
		c12_s3 <= CW'(ef_s2) - CW'(dc_s2);
		c13_s3 <= CW'(df_s2) - CW'(be_s2);
		c22_s3 <= CW'(ac_s2) - CW'(ee_s2);
		c23_s3 <= CW'(de_s2) - CW'(af_s2);
		c33_s3 <= CW'(ab_s2) - CW'(dd_s2);
		a_s3   <= a_s2;
		d_s3   <= d_s2;
		e_s3   <= e_s2;
		v1_s3  <= v1_s2;
		v2_s3  <= v2_s2;
		v3_s3  <= v3_s2;
	end

	// operand pairing for the twelve data-by-cofactor products
	logic signed [W-1:0]  x_op [mcs_pkg::NTERM];
	logic signed [CW-1:0] k_op [mcs_pkg::NTERM];

	always_comb begin
		x_op[0]  = a_s3;  k_op[0]  = c11_s3;
		x_op[1]  = d_s3;  k_op[1]  = c12_s3;
		x_op[2]  = e_s3;  k_op[2]  = c13_s3;
		x_op[3]  = v1_s3; k_op[3]  = c11_s3;
		x_op[4]  = v2_s3; k_op[4]  = c12_s3;
		x_op[5]  = v3_s3; k_op[5]  = c13_s3;
		x_op[6]  = v1_s3; k_op[6]  = c12_s3;
		x_op[7]  = v2_s3; k_op[7]  = c22_s3;
		x_op[8]  = v3_s3; k_op[8]  = c23_s3;
		x_op[9]  = v1_s3; k_op[9]  = c13_s3;
		x_op[10] = v2_s3; k_op[10] = c23_s3;
		x_op[11] = v3_s3; k_op[11] = c33_s3;
	end

	// stage 4: each product split into low and high cofactor halves
	localparam int PW = mcs_pkg::PP_W;
	logic                 valid_s4;
	logic signed [PW-1:0] lo_s4 [mcs_pkg::NTERM];
	logic signed [PW-1:0] hi_s4 [mcs_pkg::NTERM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < mcs_pkg::NTERM; j++) begin
			lo_s4[j] <= PW'(x_op[j]) * PW'($signed({1'b0, k_op[j][W-1:0]}));
			hi_s4[j] <= PW'(x_op[j]) * PW'($signed(k_op[j][CW-1:W]));
		end
	end

	// stage 5: recombine the halves
	localparam int TW = mcs_pkg::TERM_W;
	logic                 valid_s5;
	logic signed [TW-1:0] term_s5 [mcs_pkg::NTERM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < mcs_pkg::NTERM; j++) begin
			term_s5[j] <= (TW'(hi_s4[j]) <<< W) + TW'(lo_s4[j]);
		end
	end

	// stage 6: determinant and numerators
	localparam int SW = mcs_pkg::SUM_W;
	logic                 valid_s6;
	logic signed [SW-1:0] det_s6, n1_s6, n2_s6, n3_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		det_s6 <= SW'(term_s5[0]) + SW'(term_s5[1])  + SW'(term_s5[2]);
		n1_s6  <= SW'(term_s5[3]) + SW'(term_s5[4])  + SW'(term_s5[5]);
		n2_s6  <= SW'(term_s5[6]) + SW'(term_s5[7])  + SW'(term_s5[8]);
		n3_s6  <= SW'(term_s5[9]) + SW'(term_s5[10]) + SW'(term_s5[11]);
	end

	assign result.valid = valid_s6;
	assign result.det   = det_s6;
	assign result.num_1 = n1_s6;
	assign result.num_2 = n2_s6;
	assign result.num_3 = n3_s6;

endmodule

[rtl/core/mcs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_div
// Pipelined signed restoring divider: (num << FRAC_W) / den, truncated
// toward zero, saturated to the data range, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mcs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [mcs_pkg::SUM_W-1:0]  num,
	input  logic signed [mcs_pkg::SUM_W-1:0]  den,
	output logic                              out_valid,
	output logic                              out_zero,
	output logic signed [mcs_pkg::DATA_W-1:0] current
);

	localparam int W  = mcs_pkg::DATA_W;
	localparam int SW = mcs_pkg::SUM_W;
	localparam int RW = mcs_pkg::REM_W;

	// stage 1: magnitudes, sign and zero divisor
	logic          valid_s1, neg_s1, zero_s1;
	logic [SW-1:0] nmag_s1, dmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		nmag_s1 <= num[SW-1] ? SW'(-num) : SW'(num);
		dmag_s1 <= den[SW-1] ? SW'(-den) : SW'(den);
		neg_s1  <= num[SW-1] ^ den[SW-1];
		zero_s1 <= (den == '0);
	end

	// stage 2: quotient of 2^W or more saturates
	logic          valid_s2, neg_s2, zero_s2, ovf_s2;
	logic [RW-1:0] rem_s2, dsh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rem_s2  <= RW'(nmag_s1) << mcs_pkg::FRAC_W;
		dsh_s2  <= RW'(dmag_s1);
		ovf_s2  <= (RW'(nmag_s1) << mcs_pkg::FRAC_W) >= (RW'(dmag_s1) << W);
		neg_s2  <= neg_s1;
		zero_s2 <= zero_s1;
	end

	// quotient stages, most significant bit first
	logic          valid_sk [W+1];
	logic          neg_sk   [W+1];
	logic          zero_sk  [W+1];
	logic          ovf_sk   [W+1];
	logic [RW-1:0] rem_sk   [W+1];
	logic [RW-1:0] den_sk   [W+1];
	logic [W-1:0]  quo_sk   [W+1];

	assign valid_sk[0] = valid_s2;
	assign neg_sk[0]   = neg_s2;
	assign zero_sk[0]  = zero_s2;
	assign ovf_sk[0]   = ovf_s2;
	assign rem_sk[0]   = rem_s2;
	assign den_sk[0]   = dsh_s2;
	assign quo_sk[0]   = '0;

	for (genvar i = 0; i < W; i++) begin : g_step
		localparam int K = W - 1 - i;
		logic [RW-1:0] trial;
		logic          fits;

		assign trial = den_sk[i] << K;
		assign fits  = rem_sk[i] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sk[i+1] <= 1'b0;
			end else begin
				valid_sk[i+1] <= valid_sk[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_sk[i+1]  <= fits ? rem_sk[i] - trial : rem_sk[i];
			quo_sk[i+1]  <= quo_sk[i] | (fits ? (W'(1) << K) : '0);
			den_sk[i+1]  <= den_sk[i];
			neg_sk[i+1]  <= neg_sk[i];
			zero_sk[i+1] <= zero_sk[i];
			ovf_sk[i+1]  <= ovf_sk[i];
		end
	end

	// saturation and sign
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

	logic         valid_so, zero_so;
	logic [W-1:0] cur_so;
	logic [W-1:0] qf, mag;

	always_comb begin
		qf = quo_sk[W];
		if (neg_sk[W]) begin
			mag = (ovf_sk[W] || qf > MIN_MAG) ? MIN_MAG : qf;
		end else begin
			mag = (ovf_sk[W] || qf[W-1]) ? MAX_POS : qf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else begin
			valid_so <= valid_sk[W];
		end
	end

	always_ff @(posedge clk) begin
		zero_so <= zero_sk[W];
		if (zero_sk[W]) begin
			cur_so <= '0;
		end else begin
			cur_so <= neg_sk[W] ? (~mag + W'(1)) : mag;
		end
	end

	assign out_valid = valid_so;
	assign out_zero  = zero_so;
	assign current   = $signed(cur_so);

endmodule

[rtl/core/mesh_current_solver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_current_solver_core
// Solves R*I = V for two or three mesh loops in signed Q16.16.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which start is high; busy never rises.
// Each result appears on rsp with done high for one cycle; the path from its
// request runs through six stages for cofactors, determinant and numerators,
// then 35 in each divider: magnitude, range check, one stage per quotient bit
// and saturation. Results come out in request order and the receiver cannot
// hold them off. A zero determinant gives singular high and zero currents.
module mesh_current_solver_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mcs_pkg::solve_req_t req,
	output logic                done,
	output mcs_pkg::solve_rsp_t rsp
);

	mcs_pkg::adj_out_t adj;

	logic                              vld_1, vld_2, vld_3;
	logic                              zero_1, zero_2, zero_3;
	logic signed [mcs_pkg::DATA_W-1:0] cur_1, cur_2, cur_3;

	// exact adjugate and determinant
	mcs_adj u_adj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.req      (req),
		.result   (adj)
	);

	// one divider per loop current
	mcs_div u_div_1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adj.valid),
		.num       (adj.num_1),
		.den       (adj.det),
		.out_valid (vld_1),
		.out_zero  (zero_1),
		.current   (cur_1)
	);

	mcs_div u_div_2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adj.valid),
		.num       (adj.num_2),
		.den       (adj.det),
		.out_valid (vld_2),
		.out_zero  (zero_2),
		.current   (cur_2)
	);

	mcs_div u_div_3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adj.valid),
		.num       (adj.num_3),
		.den       (adj.det),
		.out_valid (vld_3),
		.out_zero  (zero_3),
		.current   (cur_3)
	);

	// result assembly
	assign busy          = 1'b0;
	assign done          = vld_1;
	assign rsp.current_1 = cur_1;
	assign rsp.current_2 = cur_2;
	assign rsp.current_3 = cur_3;
	assign rsp.singular  = zero_1;

	// checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, mcs_pkg::LATENCY))
		else $error("result without matching request");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_1 == vld_2) && (vld_1 == vld_3) && (!vld_1 || (zero_1 == zero_2 && zero_1 == zero_3)))
		else $error("divider lanes out of step");

	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.singular) |->
		(rsp.current_1 == '0 && rsp.current_2 == '0 && rsp.current_3 == '0))
		else $error("singular result with nonzero current");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for mesh_current_solver_core. Requests of two- and
// three-loop systems go in with random gaps between them. Every accepted
// request is solved exactly in wide integers, truncated and saturated, and
// the expected currents are queued. Each result strobe is then compared
// field by field with the oldest queued solution.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic signed [255:0] wide_t;

	localparam logic MODE_TWO   = 1'b0;
	localparam logic MODE_THREE = 1'b1;
	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] ONE_Q    = 32'h0001_0000;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                done;
	mcs_pkg::solve_req_t req;
	mcs_pkg::solve_rsp_t rsp;

	mcs_pkg::solve_rsp_t solutions_due[$];
	int                  error_count = 0;
	int                  gap_max     = 11;

	mesh_current_solver_core dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("tb_top: errors");
		$finish;
	end

	// exact quotient (num << frac) / det, truncated toward zero, clamped
	function automatic logic [mcs_pkg::DATA_W-1:0] scaled_quotient(wide_t num, wide_t det);
		wide_t q;
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (mcs_pkg::DATA_W - 1)) - 1;
		lo = -(wide_t'(1) <<< (mcs_pkg::DATA_W - 1));
		q = (num <<< mcs_pkg::FRAC_W) / det;
		if (q > hi) q = hi;
		if (q < lo) q = lo;
		return q[mcs_pkg::DATA_W-1:0];
	endfunction

	// mesh currents from adjugate and determinant
	function automatic mcs_pkg::solve_rsp_t mesh_solution(mcs_pkg::solve_req_t r);
		mcs_pkg::solve_rsp_t s;
		wide_t a, b, c, d, e, f, v1, v2, v3;
		wide_t c11, c12, c13, c22, c23, c33;
		wide_t det, n1, n2, n3;
		a = wide_t'(r.self_1);    b = wide_t'(r.self_2);    c = wide_t'(r.self_3);
		d = wide_t'(r.mutual_12); e = wide_t'(r.mutual_13); f = wide_t'(r.mutual_23);
		v1 = wide_t'(r.source_1); v2 = wide_t'(r.source_2); v3 = wide_t'(r.source_3);
		n3 = 0;
		if (r.mode == MODE_THREE) begin
			c11 = b * c - f * f;
			c12 = e * f - d * c;
			c13 = d * f - b * e;
			c22 = a * c - e * e;
			c23 = d * e - a * f;
			c33 = a * b - d * d;
			det = a * c11 + d * c12 + e * c13;
			n1  = c11 * v1 + c12 * v2 + c13 * v3;
			n2  = c12 * v1 + c22 * v2 + c23 * v3;
			n3  = c13 * v1 + c23 * v2 + c33 * v3;
		end else begin
			det = a * b - d * d;
			n1  = b * v1 - d * v2;
			n2  = a * v2 - d * v1;
		end
		s = '0;
		if (det == 0) begin
			s.singular = 1'b1;
		end else begin
			s.current_1 = scaled_quotient(n1, det);
			s.current_2 = scaled_quotient(n2, det);
			if (r.mode == MODE_THREE) s.current_3 = scaled_quotient(n3, det);
		end
		return s;
	endfunction

	// one request: raise start at the falling edge, hold until taken
	task automatic send_request(mcs_pkg::solve_req_t r);
		@(negedge clk);
		start = 1'b1;
		req   = r;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		solutions_due.push_back(mesh_solution(r));
	endtask

	// random idle cycles after a request
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, gap_max);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic push(mcs_pkg::solve_req_t r);
		send_request(r);
		idle_gap();
	endtask

	// hold off until every outstanding solution has come back
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (solutions_due.size() != 0) @(posedge clk);
	endtask

	function automatic mcs_pkg::solve_req_t make_req(logic m, logic [31:0] a,
		logic [31:0] b, logic [31:0] c, logic [31:0] d, logic [31:0] e, logic [31:0] f,
		logic [31:0] v1, logic [31:0] v2, logic [31:0] v3);
		mcs_pkg::solve_req_t r;
		r.mode = m;
		r.self_1 = a; r.self_2 = b; r.self_3 = c;
		r.mutual_12 = d; r.mutual_13 = e; r.mutual_23 = f;
		r.source_1 = v1; r.source_2 = v2; r.source_3 = v3;
		return r;
	endfunction

	// random word: full range, small Q16.16 value or an extreme
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2, 3, 4: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			default: begin
				case ($urandom_range(0, 4))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return 32'h0;
					3: return 32'hffff_ffff;
					default: return 32'h1;
				endcase
			end
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		mcs_pkg::solve_rsp_t want;
		if (arst_n && done) begin
			if (solutions_due.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				want = solutions_due.pop_front();
				if (rsp.current_1 !== want.current_1) begin
					$error("current_1 exp %h got %h", want.current_1, rsp.current_1);
					error_count++;
				end
				if (rsp.current_2 !== want.current_2) begin
					$error("current_2 exp %h got %h", want.current_2, rsp.current_2);
					error_count++;
				end
				if (rsp.current_3 !== want.current_3) begin
					$error("current_3 exp %h got %h", want.current_3, rsp.current_3);
					error_count++;
				end
				if (rsp.singular !== want.singular) begin
					$error("singular exp %b got %b", want.singular, rsp.singular);
					error_count++;
				end
			end
		end
	end

	// identity and coupled systems in both modes
	task automatic test_basic_systems();
		push(make_req(MODE_TWO, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, ONE_Q, 32'hfffe_0000, 32'h0005_0000));
		push(make_req(MODE_THREE, ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, ONE_Q, 32'hfffe_0000, 32'h0003_8000));
		push(make_req(MODE_THREE, 32'h000a_0000, 32'h0008_0000, 32'h0006_0000,
			32'hfffe_0000, 32'hffff_0000, 32'hfffd_0000, 32'h000c_0000, 0, 32'hfffb_0000));
		push(make_req(MODE_TWO, 32'h0003_0000, 32'h0005_0000, 0,
			32'hfffe_0000, 0, 0, 32'h0001_0000, 32'h0002_0000, 0));
		// negative determinant
		push(make_req(MODE_TWO, ONE_Q, ONE_Q, 0, 32'h0002_0000, 0, 0, ONE_Q, ONE_Q, 0));
	endtask

	// two-loop mode must ignore the third-loop fields
	task automatic test_ignored_fields();
		push(make_req(MODE_TWO, 32'h0004_0000, 32'h0002_0000, WORD_MIN, 32'h0001_0000,
			WORD_MAX, 32'hdead_beef, 32'h0003_0000, 32'hffff_0000, WORD_MAX));
		push(make_req(MODE_TWO, 32'h0004_0000, 32'h0002_0000, 32'hffff_ffff, 32'h0001_0000,
			32'hffff_ffff, 32'hffff_ffff, 32'h0003_0000, 32'hffff_0000, 32'hffff_ffff));
	endtask

	// zero determinant: dependent rows, all zero matrix
	task automatic test_singular();
		push(make_req(MODE_TWO, 0, 0, 0, 0, 0, 0, ONE_Q, ONE_Q, ONE_Q));
		push(make_req(MODE_TWO, 32'h0002_0000, 32'h0002_0000, 0, 32'h0002_0000, 0, 0,
			ONE_Q, 0, 0));
		push(make_req(MODE_THREE, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q));
		push(make_req(MODE_THREE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
			WORD_MIN, WORD_MAX, 0));
	endtask

	// extreme words and saturation of tiny determinants
	task automatic test_extremes();
		push(make_req(MODE_THREE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MIN,
			WORD_MAX, WORD_MIN, WORD_MAX));
		push(make_req(MODE_THREE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX,
			WORD_MIN, WORD_MIN, WORD_MIN));
		push(make_req(MODE_TWO, WORD_MIN, WORD_MIN, 0, WORD_MAX, 0, 0, WORD_MAX, WORD_MIN, 0));
		push(make_req(MODE_TWO, 32'h1, 32'h1, 0, 0, 0, 0, WORD_MAX, WORD_MIN, 0));
		push(make_req(MODE_THREE, 32'h1, 32'h1, 32'h1, 0, 0, 0, WORD_MAX, WORD_MIN, 32'h1));
		push(make_req(MODE_THREE, 32'hffff_ffff, 32'h1, 32'h1, 0, 0, 0, WORD_MIN, 32'h1,
			WORD_MIN));
		push(make_req(MODE_THREE, WORD_MAX, 32'h1, WORD_MIN, 32'hffff_ffff, 32'h1, 0,
			32'hffff_ffff, 0, 32'h1));
	endtask

	// random systems, back to back and with gaps
	task automatic test_random_systems(int count);
		mcs_pkg::solve_req_t r;
		logic [31:0] w;
		for (int i = 0; i < count; i++) begin
			r = make_req(1'($urandom_range(0, 1)), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
			// now and then build a dependent matrix
			if ($urandom_range(0, 15) == 0) begin
				w = rand_word();
				r.self_1 = w; r.self_2 = w; r.self_3 = w;
				r.mutual_12 = w; r.mutual_13 = w; r.mutual_23 = w;
			end
			// stretches with no idling
			gap_max = (i % 200 < 50) ? 0 : 11;
			push(r);
			if (i == count / 2) drain();
		end
		gap_max = 11;
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_systems();
		test_ignored_fields();
		test_singular();
		test_extremes();
		drain();
		test_random_systems(800);

		drain();
		repeat (mcs_pkg::LATENCY + 10) @(posedge clk);
		if (error_count == 0 && solutions_due.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/mcs_pkg.sv
rtl/core/mcs_adj.sv
rtl/core/mcs_div.sv
rtl/core/mesh_current_solver_core.sv
verif/tb_top.sv
